// ----- rtl/ist_pkg.sv -----
`timescale 1ns / 1ps
package ist_pkg;

   localparam int TABLE_ENTRIES = 256;
   localparam int ADDR_W        = $clog2(TABLE_ENTRIES);
   localparam int MAX_CHANNELS  = 8;
   localparam int CHAN_W        = 3;
   localparam int COUNT_W       = 4;
   localparam int PHASE_W       = 32;
   localparam int FRAC_W        = 16;
   localparam int SAMPLE_W      = 16;
   localparam int AMP_W         = 15;
   localparam int CSR_INDEX_W   = 4;
   localparam int CSR_DATA_W    = 32;

   localparam logic [CSR_INDEX_W-1:0] REG_PHASE_STEP    = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_AMPLITUDE     = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_CHANNEL_COUNT = 4'd2;

   localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C235;

   typedef logic [TABLE_ENTRIES-1:0][SAMPLE_W-1:0] rom_type;

   typedef struct packed {
      logic rom_rd;
      logic interp_en;
      logic scale_en;
      logic mult_en;
   } ctrl_type;

   function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = 128'(a) * 128'(b);
      return p[125:62];
   endfunction

   function automatic logic [63:0] series_sin(input logic [63:0] x);
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      x2   = mul_q62(x, x);
      term = x;
      sum  = x;
      for (int n = 1; n <= 6; n++) begin
         case (n)
            1: term = mul_q62(term, x2) / 64'd6;
            2: term = mul_q62(term, x2) / 64'd20;
            3: term = mul_q62(term, x2) / 64'd42;
            4: term = mul_q62(term, x2) / 64'd72;
            5: term = mul_q62(term, x2) / 64'd110;
            default: term = mul_q62(term, x2) / 64'd156;
         endcase
         if (n % 2 == 1) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      return sum;
   endfunction

   function automatic rom_type build_rom();
      rom_type            rom;
      logic [63:0]        step;
      logic [63:0]        prod;
      logic signed [31:0] v;
      int                 k;
      step = PI_Q62 / (TABLE_ENTRIES / 2);
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         k = i % (TABLE_ENTRIES / 2);
         if (k > TABLE_ENTRIES / 4) begin
            k = TABLE_ENTRIES / 2 - k;
         end
         prod = mul_q62(series_sin(step * 64'(k)), 64'd32767);
         v    = prod[31:0];
         if (v > 32'sd32767) begin
            v = 32'sd32767;
         end
         if (i >= TABLE_ENTRIES / 2) begin
            v = -v;
         end
         rom[i] = v[SAMPLE_W-1:0];
      end
      return rom;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

endpackage

// ----- rtl/ist_if.sv -----
`timescale 1ns / 1ps
interface ist_req_if;
   logic valid;
   logic ready;
   logic frame_tick;
   modport source (output valid, output frame_tick, input ready);
   modport sink (input valid, input frame_tick, output ready);
endinterface

interface ist_rsp_if;
   import ist_pkg::*;
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample;
   logic [CHAN_W-1:0]   channel_index;
   logic                last_channel;
   modport source (output valid, output sample, output channel_index, output last_channel,
                   input ready);
   modport sink (input valid, input sample, input channel_index, input last_channel,
                 output ready);
endinterface

interface ist_csr_if;
   import ist_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/ist_interp.sv -----
`timescale 1ns / 1ps
module ist_interp (
   input  logic                                clock,
   input  ist_pkg::ctrl_type                   ctrl,
   input  logic [ist_pkg::PHASE_W-1:0]         phase,
   input  logic [ist_pkg::AMP_W-1:0]           amplitude,
   output logic signed [ist_pkg::SAMPLE_W-1:0] sample
);
   import ist_pkg::*;

   logic signed [SAMPLE_W-1:0]         first_ff;
   logic signed [SAMPLE_W-1:0]         second_ff;
   logic [FRAC_W-1:0]                  frac_ff;
   logic signed [SAMPLE_W+FRAC_W+1:0]  prod_ff;
   logic signed [SAMPLE_W:0]           interp_ff;
   logic signed [SAMPLE_W-1:0]         sample_ff;

   logic [ADDR_W-1:0]                  idx;
   logic [ADDR_W-1:0]                  nxt;
   logic signed [SAMPLE_W:0]           diff;
   logic signed [SAMPLE_W+FRAC_W+1:0]  prod_in;
   logic signed [SAMPLE_W+1:0]         interp_wide;
   logic signed [SAMPLE_W+AMP_W+1:0]   scaled;

   assign idx         = phase[PHASE_W-1 -: ADDR_W];
   assign nxt         = idx + 1'b1;
   assign diff        = (SAMPLE_W+1)'(second_ff) - (SAMPLE_W+1)'(first_ff);
   assign prod_in     = (SAMPLE_W+FRAC_W+2)'(diff)
                        * (SAMPLE_W+FRAC_W+2)'(signed'({1'b0, frac_ff}));
   assign interp_wide = (SAMPLE_W+2)'(first_ff) + (SAMPLE_W+2)'(prod_ff >>> FRAC_W);
   assign scaled      = (SAMPLE_W+AMP_W+2)'(interp_ff)
                        * (SAMPLE_W+AMP_W+2)'(signed'({1'b0, amplitude}));

   always_ff @(posedge clock) begin
      if (ctrl.rom_rd) begin
         first_ff  <= SINE_ROM[idx];
         second_ff <= SINE_ROM[nxt];
         frac_ff   <= phase[PHASE_W-ADDR_W-1 -: FRAC_W];
      end
      if (ctrl.interp_en) begin
         prod_ff <= prod_in;
      end
      if (ctrl.scale_en) begin
         interp_ff <= interp_wide[SAMPLE_W:0];
      end
      if (ctrl.mult_en) begin
         sample_ff <= scaled[AMP_W +: SAMPLE_W];
      end
   end

   assign sample = sample_ff;

endmodule

// ----- rtl/interpolated_sine_tone_generator_top.sv -----
`timescale 1ns / 1ps
// Channel   Dir  Payload                                   Transfer
// req_bus   in   frame_tick                                valid & ready
// rsp_bus   out  sample, channel_index, last_channel       valid & ready
// csr_bus   in   index, data (0 step, 1 amplitude, 2 chans) valid & ready
//
// A frame passes through ROM read, interpolate, scale and multiply, then
// one channel result per cycle while rsp is ready; ready returns the cycle after the last.
// A tick of 0 or a channel count of 0 is taken in idle and emits nothing.
// Reset clears phase, step and amplitude, sets the channel count to 1 and idles control; the ROM is constant.
// rsp stalls hold the current channel result; req is not taken until done.
module interpolated_sine_tone_generator_top (
   input  logic      clock,
   input  logic      reset,
   ist_req_if.sink   req_bus,
   ist_rsp_if.source rsp_bus,
   ist_csr_if.sink   csr_bus
);
   import ist_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_INTERP = 3'd1;
   localparam logic [2:0] S_SCALE  = 3'd2;
   localparam logic [2:0] S_MULT   = 3'd3;
   localparam logic [2:0] S_EMIT   = 3'd4;

   logic [2:0]         state_ff, state_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [PHASE_W-1:0] step_ff;
   logic [AMP_W-1:0]   amp_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] chans_ff, chans_in;
   logic [CHAN_W-1:0]  chan_ff, chan_in;

   logic                      req_xfer;
   logic                      rsp_xfer;
   logic                      last;
   logic [COUNT_W-1:0]        chans_sat;
   ctrl_type                  ctrl;
   logic signed [SAMPLE_W-1:0] sample;

   assign req_bus.ready = (state_ff == S_IDLE);
   assign csr_bus.ready = 1'b1;
   assign req_xfer      = req_bus.valid && req_bus.ready;
   assign rsp_xfer      = rsp_bus.valid && rsp_bus.ready;
   assign chans_sat     = (count_ff > COUNT_W'(MAX_CHANNELS)) ? COUNT_W'(MAX_CHANNELS) : count_ff;
   assign last          = (COUNT_W'(chan_ff) + 1'b1) == chans_ff;

   assign ctrl.rom_rd    = req_xfer;
   assign ctrl.interp_en = (state_ff == S_INTERP);
   assign ctrl.scale_en  = (state_ff == S_SCALE);
   assign ctrl.mult_en   = (state_ff == S_MULT);

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      chans_in = chans_ff;
      chan_in  = chan_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer && req_bus.frame_tick) begin
               phase_in = phase_ff + step_ff;
               chans_in = chans_sat;
               chan_in  = '0;
               if (chans_sat != '0) begin
                  state_in = S_INTERP;
               end
            end
         end
         S_INTERP: state_in = S_SCALE;
         S_SCALE:  state_in = S_MULT;
         S_MULT:   state_in = S_EMIT;
         S_EMIT: begin
            if (rsp_xfer) begin
               if (last) begin
                  state_in = S_IDLE;
               end else begin
                  chan_in = chan_ff + 1'b1;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= '0;
         step_ff  <= '0;
         amp_ff   <= '0;
         count_ff <= COUNT_W'(1);
         chans_ff <= '0;
         chan_ff  <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         chans_ff <= chans_in;
         chan_ff  <= chan_in;
         if (csr_bus.valid && csr_bus.ready) begin
            unique case (csr_bus.index)
               REG_PHASE_STEP:    step_ff  <= csr_bus.data[PHASE_W-1:0];
               REG_AMPLITUDE:     amp_ff   <= csr_bus.data[AMP_W-1:0];
               REG_CHANNEL_COUNT: count_ff <= csr_bus.data[COUNT_W-1:0];
               default: ;
            endcase
         end
      end
   end

   ist_interp u_interp (
      .clock     (clock),
      .ctrl      (ctrl),
      .phase     (phase_ff),
      .amplitude (amp_ff),
      .sample    (sample)
   );

   assign rsp_bus.valid         = (state_ff == S_EMIT);
   assign rsp_bus.sample        = sample;
   assign rsp_bus.channel_index = chan_ff;
   assign rsp_bus.last_channel  = last;

endmodule

// ----- verif/tb_interpolated_sine_tone_generator_top.sv -----
`timescale 1ns / 1ps
module tb_interpolated_sine_tone_generator_top;

   localparam logic [63:0] HALF_TURN_Q62 = 64'hC90FDAA22168C235;
   localparam int          LUT_SIZE      = 256;
   localparam int          CHAN_LIMIT    = 8;
   localparam logic [3:0]  REG_SPARE     = 4'd3;
   localparam logic [3:0]  REG_TOP       = 4'hF;
   localparam int          HOLD_AFTER    = 300;
   localparam int          HOLD_CYCLES   = 400;
   localparam int          SETTLE_CYCLES = 10;

   typedef struct packed {
      logic signed [15:0] sample;
      logic [2:0]         channel;
      logic               last;
   } chan_sample_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ist_req_if req_bus ();
   ist_rsp_if rsp_bus ();
   ist_csr_if csr_bus ();

   interpolated_sine_tone_generator_top u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #6 clock = ~clock;

   logic signed [15:0] sine_lut [LUT_SIZE];
   logic [31:0]        step_cfg  = '0;
   logic [14:0]        gain_cfg  = '0;
   logic [3:0]         chans_cfg = 4'd1;
   logic [31:0]        acc_phase = '0;

   logic            tick_queue [$];
   chan_sample_type expected_samples [$];
   chan_sample_type want;

   int  errors          = 0;
   int  samples_checked = 0;
   int  active_ticks    = 0;
   int  idle_ticks      = 0;
   int  reg_writes      = 0;
   int  send_gap        = 0;
   int  recv_gap        = 0;
   int  hold_left       = 0;
   bit  hold_done       = 0;
   bit  sender_gaps_on  = 0;
   bit  rsp_stalls_on   = 0;

   function automatic logic [63:0] q62_product(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] wide;
      wide = {64'd0, a} * {64'd0, b};
      return wide[125:62];
   endfunction

   function automatic logic [63:0] sine_series_q62(input logic [63:0] x);
      logic [63:0] sq;
      logic [63:0] term;
      logic [63:0] acc;
      int          n;
      sq   = q62_product(x, x);
      term = x;
      acc  = x;
      for (n = 1; n <= 6; n++) begin
         term = q62_product(term, sq) / 64'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) begin
            acc = acc - term;
         end else begin
            acc = acc + term;
         end
      end
      return acc;
   endfunction

   task automatic fill_sine_lut();
      logic [63:0]        angle_step;
      logic [63:0]        prod;
      logic signed [31:0] v;
      int                 k;
      int                 i;
      angle_step = HALF_TURN_Q62 / (LUT_SIZE / 2);
      for (i = 0; i < LUT_SIZE; i++) begin
         k = i % (LUT_SIZE / 2);
         if (k > LUT_SIZE / 4) begin
            k = LUT_SIZE / 2 - k;
         end
         prod = q62_product(sine_series_q62(angle_step * 64'(k)), 64'd32767);
         v    = prod[31:0];
         if (v > 32'sd32767) begin
            v = 32'sd32767;
         end
         if (i >= LUT_SIZE / 2) begin
            v = -v;
         end
         sine_lut[i] = v[15:0];
      end
   endtask

   function automatic logic signed [15:0] sine_at(input logic [31:0] ph, input logic [14:0] gain);
      logic [7:0]         idx;
      logic [7:0]         nxt;
      logic signed [63:0] lo_v;
      logic signed [63:0] hi_v;
      logic signed [63:0] frac;
      logic signed [63:0] interp;
      logic signed [63:0] scaled;
      idx    = ph[31:24];
      nxt    = idx + 8'd1;
      lo_v   = sine_lut[idx];
      hi_v   = sine_lut[nxt];
      frac   = $signed({48'd0, ph[23:8]});
      interp = lo_v + (((hi_v - lo_v) * frac) >>> 16);
      scaled = (interp * $signed({49'd0, gain})) >>> 15;
      return scaled[15:0];
   endfunction

   task automatic predict_frame(input logic tick);
      logic signed [15:0] s;
      int                 n;
      int                 c;
      chan_sample_type    e;
      if (!tick) begin
         return;
      end
      s = sine_at(acc_phase, gain_cfg);
      n = (chans_cfg > CHAN_LIMIT) ? CHAN_LIMIT : int'(chans_cfg);
      for (c = 0; c < n; c++) begin
         e.sample  = s;
         e.channel = c[2:0];
         e.last    = (c + 1 == n);
         expected_samples.push_back(e);
      end
      acc_phase = acc_phase + step_cfg;
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end else if (r < 85) begin
         return $urandom_range(1, 3);
      end else if (r < 95) begin
         return $urandom_range(4, 10);
      end
      return $urandom_range(20, 60);
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid      <= 1'b0;
         req_bus.frame_tick <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            predict_frame(req_bus.frame_tick);
            void'(tick_queue.pop_front());
            send_gap = sender_gaps_on ? pick_gap() : 0;
         end
         if (req_bus.valid && !req_bus.ready) begin
            // hold the offered item until transfer
         end else if (send_gap > 0) begin
            send_gap--;
            req_bus.valid <= 1'b0;
         end else if (tick_queue.size() > 0) begin
            req_bus.valid      <= 1'b1;
            req_bus.frame_tick <= tick_queue[0];
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         recv_gap = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_samples.size() == 0) begin
               $display("%0t: unexpected transfer: sample %0d channel %0d last %0b", $time,
                        $signed(rsp_bus.sample), rsp_bus.channel_index, rsp_bus.last_channel);
               errors++;
            end else begin
               want = expected_samples.pop_front();
               if (rsp_bus.sample !== want.sample) begin
                  $display("%0t: sample mismatch: expected %0d, actual %0d", $time,
                           want.sample, $signed(rsp_bus.sample));
                  errors++;
               end
               if (rsp_bus.channel_index !== want.channel) begin
                  $display("%0t: channel_index mismatch: expected %0d, actual %0d", $time,
                           want.channel, rsp_bus.channel_index);
                  errors++;
               end
               if (rsp_bus.last_channel !== want.last) begin
                  $display("%0t: last_channel mismatch: expected %0b, actual %0b", $time,
                           want.last, rsp_bus.last_channel);
                  errors++;
               end
               samples_checked++;
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (!hold_done && samples_checked >= HOLD_AFTER) begin
            hold_done = 1;
            hold_left = HOLD_CYCLES;
            rsp_bus.ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (rsp_stalls_on && $urandom_range(0, 2) == 0) begin
               recv_gap = pick_gap();
            end
         end
      end
   end

   task automatic write_reg(input logic [3:0] idx, input logic [31:0] value);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      reg_writes++;
      case (idx)
         ist_pkg::REG_PHASE_STEP:    step_cfg  = value;
         ist_pkg::REG_AMPLITUDE:     gain_cfg  = value[14:0];
         ist_pkg::REG_CHANNEL_COUNT: chans_cfg = value[3:0];
         default: ;
      endcase
   endtask

   task automatic push_tick(input logic t);
      tick_queue.push_back(t);
      if (t) begin
         active_ticks++;
      end else begin
         idle_ticks++;
      end
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (tick_queue.size() != 0 || expected_samples.size() != 0 || req_bus.valid);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_step();
      case ($urandom_range(0, 5))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2: return $urandom_range(1, 32'h0010_0000);
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [31:0] pick_gain();
      case ($urandom_range(0, 5))
         0: return 32'd0;
         1: return 32'h0000_7FFF;
         2: return $urandom();
         default: return $urandom_range(0, 32767);
      endcase
   endfunction

   function automatic logic [31:0] pick_chans();
      case ($urandom_range(0, 9))
         0: return $urandom_range(0, 15);
         1: return $urandom();
         default: return $urandom_range(1, 8);
      endcase
   endfunction

   initial begin
      int p;
      int n;
      req_bus.valid      = 1'b0;
      req_bus.frame_tick = 1'b0;
      rsp_bus.ready      = 1'b0;
      csr_bus.valid      = 1'b0;
      csr_bus.index      = '0;
      csr_bus.data       = '0;
      fill_sine_lut();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // defaults out of reset, then an idle tick
      push_tick(1'b1);
      push_tick(1'b0);
      wait_drained();

      // quarter-turn steps at full gain across all channels
      write_reg(ist_pkg::REG_AMPLITUDE, 32'h0000_7FFF);
      write_reg(ist_pkg::REG_CHANNEL_COUNT, 32'd8);
      write_reg(ist_pkg::REG_PHASE_STEP, 32'h4000_0000);
      repeat (4) push_tick(1'b1);
      wait_drained();

      // lands in the last table entry, interpolating across the wrap
      write_reg(ist_pkg::REG_PHASE_STEP, 32'hFF80_FF00);
      repeat (3) push_tick(1'b1);
      wait_drained();

      write_reg(REG_SPARE, $urandom());
      write_reg(REG_TOP, 32'hFFFF_FFFF);
      write_reg(ist_pkg::REG_CHANNEL_COUNT, 32'd0);
      repeat (2) push_tick(1'b1);
      wait_drained();

      write_reg(ist_pkg::REG_CHANNEL_COUNT, 32'hFFFF_FFFF);
      push_tick(1'b1);
      wait_drained();

      write_reg(ist_pkg::REG_CHANNEL_COUNT, 32'd9);
      write_reg(ist_pkg::REG_AMPLITUDE, 32'hFFFF_8000);
      push_tick(1'b1);
      wait_drained();

      write_reg(ist_pkg::REG_AMPLITUDE, 32'h0000_7FFF);
      write_reg(ist_pkg::REG_CHANNEL_COUNT, 32'd1);
      write_reg(ist_pkg::REG_PHASE_STEP, 32'hFFFF_FFFF);
      repeat (3) push_tick(1'b1);
      push_tick(1'b0);
      wait_drained();

      for (p = 0; p < 5; p++) begin
         sender_gaps_on = (p % 2 == 1) || (p == 4);
         rsp_stalls_on  = (p != 0);
         write_reg(ist_pkg::REG_PHASE_STEP, pick_step());
         write_reg(ist_pkg::REG_AMPLITUDE, pick_gain());
         write_reg(ist_pkg::REG_CHANNEL_COUNT, pick_chans());
         write_reg(4'($urandom_range(3, 15)), $urandom());
         n = 0;
         while (n < 40) begin
            if ($urandom_range(0, 9) == 0) begin
               push_tick(1'b0);
            end else begin
               push_tick(1'b1);
               n++;
            end
         end
         wait_drained();
      end

      if (expected_samples.size() != 0) begin
         $display("%0t: %0d expected samples never arrived", $time, expected_samples.size());
         errors++;
      end
      $display("Ran %0d frame ticks and %0d idle ticks over %0d register writes;",
               active_ticks, idle_ticks, reg_writes);
      $display("checked %0d channel samples, %0d errors.", samples_checked, errors);
      if (errors == 0) begin
         $display("interpolated_sine_tone_generator_top test passed");
      end else begin
         $display("interpolated_sine_tone_generator_top test failed");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("interpolated_sine_tone_generator_top test failed");
      $finish;
   end

endmodule
